>>> hw/rtl/mrema_pkg.sv
// shared types, constants and the shift table of the moving average bank
// used by mrema_alu, mrema_div, multi_rate_ema_bank_top and mrema_chk; no dependencies
package mrema_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int DIV_BITS        = 16;
  localparam int NUM_AVG         = 7;
  localparam int IDX_BITS        = 3;
  localparam int SH_BITS         = 3;

  // average slots
  localparam logic [IDX_BITS-1:0] IDX_TUNE   = 3'd0;
  localparam logic [IDX_BITS-1:0] IDX_BY8    = 3'd1;
  localparam logic [IDX_BITS-1:0] IDX_BY16   = 3'd2;
  localparam logic [IDX_BITS-1:0] IDX_BY32   = 3'd3;
  localparam logic [IDX_BITS-1:0] IDX_BY64   = 3'd4;
  localparam logic [IDX_BITS-1:0] IDX_BY128  = 3'd5;
  localparam logic [IDX_BITS-1:0] IDX_ASYM   = 3'd6;

  // power of two shifts
  localparam logic [SH_BITS-1:0] SH_NONE = 3'd0;
  localparam logic [SH_BITS-1:0] SH_8    = 3'd3;
  localparam logic [SH_BITS-1:0] SH_16   = 3'd4;
  localparam logic [SH_BITS-1:0] SH_32   = 3'd5;
  localparam logic [SH_BITS-1:0] SH_64   = 3'd6;
  localparam logic [SH_BITS-1:0] SH_128  = 3'd7;

  localparam logic [DIV_BITS-1:0] DIV_RESET = 16'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FIX,
    S_WAIT,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // shift for a fixed-divisor slot; the asymmetric one rises by 128, falls by 32
  function automatic logic [SH_BITS-1:0] shift_of(input logic [IDX_BITS-1:0] idx,
                                                  input logic rising);
    logic [SH_BITS-1:0] sh;
    case (idx)
      IDX_BY8:   sh = SH_8;
      IDX_BY16:  sh = SH_16;
      IDX_BY32:  sh = SH_32;
      IDX_BY64:  sh = SH_64;
      IDX_BY128: sh = SH_128;
      IDX_ASYM:  sh = rising ? SH_128 : SH_32;
      default:   sh = SH_NONE;
    endcase
    return sh;
  endfunction

endpackage

>>> hw/rtl/mrema_alu.sv
// shared update unit: moves one average toward the target by a shifted
// distance or by a divider quotient; depends on mrema_pkg
module mrema_alu
  import mrema_pkg::*;
#(
  parameter int ACC_BITS = SAMPLE_BITS_DEF + FRAC_BITS_DEF
) (
  input  logic [ACC_BITS-1:0] acc,
  input  logic [ACC_BITS-1:0] target,
  input  logic [IDX_BITS-1:0] idx,
  input  logic                use_quo,
  input  logic [ACC_BITS-1:0] quo,
  output logic [ACC_BITS-1:0] diff,
  output logic [ACC_BITS-1:0] result
);

  logic                ge;
  logic                gt;
  logic [SH_BITS-1:0]  sh;
  logic [ACC_BITS-1:0] step;

  always_comb begin
    ge     = (target >= acc);
    gt     = (target > acc);
    diff   = ge ? (target - acc) : (acc - target);
    sh     = shift_of(idx, gt);
    step   = use_quo ? quo : (diff >> sh);
    result = ge ? (acc + step) : (acc - step);
  end

endmodule

>>> hw/rtl/mrema_div.sv
// restoring divider, one quotient bit per cycle
// depends on mrema_pkg
module mrema_div
  import mrema_pkg::*;
#(
  parameter int ACC_BITS = SAMPLE_BITS_DEF + FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ACC_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic [ACC_BITS-1:0] quotient,
  output div_stat_t           stat
);

  localparam int CNT_BITS = $clog2(ACC_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] dsr;
  logic [ACC_BITS-1:0] quo;
  logic                busy;
  logic                done;
  logic [DIV_BITS:0]   shifted;
  logic                fits;

  always_comb begin
    shifted = {rem, quo[ACC_BITS-1]};
    fits    = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_BITS'(ACC_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DIV_BITS'(shifted - {1'b0, dsr}) : shifted[DIV_BITS-1:0];
      quo <= {quo[ACC_BITS-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> hw/rtl/multi_rate_ema_bank_top.sv
// top level of the multi-rate moving average bank: sequencer, average registers,
// config register and output register; depends on mrema_pkg, mrema_alu, mrema_div
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+---------------------------------
//   in      | in        | in_valid / in_stall | sample
//   out     | out       | out_valid/out_stall | raw_sample and seven averages
//   cfg     | in        | cfg_valid/cfg_ready | cfg_data -> ema_divisor
//
// a primed sample runs S_LOAD, S_FIX for each fixed-divisor slot, S_WAIT until the
//   one-bit-per-cycle divider of the tunable average is done, S_APPLY and S_DONE;
//   the first sample after reset goes from accept straight to S_DONE
// in_stall is high from accept until the result is moved to the output register
// the output register lets the next sample in while a result waits on out_stall
// reset clears the sequencer, the primed flag and the divisor (back to 4)
module multi_rate_ema_bank_top
  import mrema_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [SAMPLE_BITS-1:0]           raw_sample,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] avg_tunable,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] avg_by8,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] avg_by16,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] avg_by32,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] avg_by64,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] avg_by128,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] avg_asym,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [DIV_BITS-1:0]              cfg_data
);

  localparam int ACC_BITS = SAMPLE_BITS + FRAC_BITS;

  state_t state;
  state_t state_next;

  logic                primed;
  logic [DIV_BITS-1:0] ema_divisor;
  logic [DIV_BITS-1:0] div_eff;
  logic [SAMPLE_BITS-1:0] raw;
  logic [ACC_BITS-1:0] target;
  logic [ACC_BITS-1:0] target_in;
  logic [IDX_BITS-1:0] fix_idx;
  logic [ACC_BITS-1:0] avg [NUM_AVG];

  // sequencer controls
  logic                accept;
  logic                prime_load;
  logic [IDX_BITS-1:0] alu_idx;
  logic                alu_use_quo;
  logic                avg_we;
  logic                div_start;
  logic                out_load;

  logic [ACC_BITS-1:0] alu_diff;
  logic [ACC_BITS-1:0] alu_result;
  logic [ACC_BITS-1:0] quotient;
  div_stat_t           div_stat;

  assign target_in = {sample, {FRAC_BITS{1'b0}}};
  // a zero divisor acts as one
  assign div_eff   = (ema_divisor == '0) ? {{(DIV_BITS-1){1'b0}}, 1'b1} : ema_divisor;

  // config must be written only while idle; the block itself does not enforce this, so the port is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ema_divisor <= DIV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ema_divisor <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = primed ? S_LOAD : S_DONE;
      S_LOAD:  state_next = S_FIX;
      S_FIX:   if (fix_idx == IDX_ASYM) state_next = S_WAIT;
      S_WAIT:  if (div_stat.done) state_next = S_APPLY;
      S_APPLY: state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // controls
  always_comb begin
    in_stall    = (state != S_IDLE);
    accept      = 1'b0;
    prime_load  = 1'b0;
    alu_idx     = IDX_TUNE;
    alu_use_quo = 1'b0;
    avg_we      = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state)
      S_IDLE: begin
        accept     = in_valid;
        prime_load = in_valid && !primed;
      end
      S_LOAD: begin
        // distance of the tunable average goes to the divider
        div_start = 1'b1;
      end
      S_FIX: begin
        alu_idx = fix_idx;
        avg_we  = 1'b1;
      end
      S_APPLY: begin
        alu_use_quo = 1'b1;
        avg_we      = 1'b1;
      end
      S_DONE: begin
        out_load = !out_valid || !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      primed <= 1'b0;
    end else begin
      state <= state_next;
      if (prime_load) primed <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw    <= sample;
      target <= target_in;
    end
    if (state == S_LOAD) begin
      fix_idx <= IDX_BY8;
    end else if (state == S_FIX) begin
      fix_idx <= fix_idx + 1'b1;
    end
  end

  // average bank; the first sample loads every slot
  always_ff @(posedge clk) begin
    if (prime_load) begin
      for (int i = 0; i < NUM_AVG; i++) begin
        avg[i] <= target_in;
      end
    end else if (avg_we) begin
      avg[alu_idx] <= alu_result;
    end
  end

  mrema_alu #(
    .ACC_BITS (ACC_BITS)
  ) u_alu (
    .acc     (avg[alu_idx]),
    .target  (target),
    .idx     (alu_idx),
    .use_quo (alu_use_quo),
    .quo     (quotient),
    .diff    (alu_diff),
    .result  (alu_result)
  );

  mrema_div #(
    .ACC_BITS (ACC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (alu_diff),
    .divisor  (div_eff),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      raw_sample  <= raw;
      avg_tunable <= avg[IDX_TUNE];
      avg_by8     <= avg[IDX_BY8];
      avg_by16    <= avg[IDX_BY16];
      avg_by32    <= avg[IDX_BY32];
      avg_by64    <= avg[IDX_BY64];
      avg_by128   <= avg[IDX_BY128];
      avg_asym    <= avg[IDX_ASYM];
    end
  end

endmodule

>>> hw/rtl/mrema_chk.sv
// port-level checks of the moving average bank, bound to the top level
// depends on mrema_pkg and multi_rate_ema_bank_top
module mrema_chk
  import mrema_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [SAMPLE_BITS-1:0]           sample,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [SAMPLE_BITS-1:0]           raw_sample,
  input logic [SAMPLE_BITS+FRAC_BITS-1:0] avg_by8
);

  logic [SAMPLE_BITS-1:0] last_sample;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) last_sample <= sample;
  end

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous word still in work");

  // a result never shows up the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a new result carries the sample it came from
  a_raw_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> raw_sample == last_sample)
    else $error("raw_sample does not match accepted sample");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(raw_sample) && $stable(avg_by8))
    else $error("stalled result changed");

endmodule

bind multi_rate_ema_bank_top mrema_chk #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_chk (.*);
